>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is applied.
`define ASSERT_CLK(label, clk_sig, rst_n_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define ASSERT_CLK_ALWAYS(label, clk_sig, prop, msg) \
	label: assert property (@(posedge clk_sig) prop) else $error(msg);

`endif

>>> rtl/rthc_pkg.sv
// ----------------------------------------------------------------------------
// rthc_pkg
// Types and constants for the RGB to HSV converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rthc_pkg;

	localparam int CHAN_W    = 8;
	localparam int HUE_W     = 13;
	localparam int SAT_W     = 16;

	// restoring divider geometry: numerator < den * 2**DIV_QUO_W holds whenever den is non-zero
	localparam int DIV_DEN_W = 8;
	localparam int DIV_QUO_W = 16;
	localparam int DIV_NUM_W = DIV_DEN_W + DIV_QUO_W;

	localparam logic [HUE_W-1:0] HUE_SECTOR = 13'd960;
	localparam logic [HUE_W-1:0] HUE_FULL   = 13'd5760;

	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	// side information carried alongside the divider stages
	typedef struct packed {
		logic [CHAN_W-1:0] bright;
		logic [1:0]        sector;
		logic              neg;
		logic              grey;
	} side_t;

endpackage

>>> rtl/rthc_div.sv
// ----------------------------------------------------------------------------
// rthc_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rthc_div (
	input  logic                              clk,
	input  logic [rthc_pkg::DIV_QUO_W-1:0]    stage_en, // load enable, one per stage
	input  logic [rthc_pkg::DIV_NUM_W-1:0]    num,
	input  logic [rthc_pkg::DIV_DEN_W-1:0]    den,
	output logic [rthc_pkg::DIV_QUO_W-1:0]    quo,
	output logic [rthc_pkg::DIV_DEN_W-1:0]    rem
);
	import rthc_pkg::*;

	logic [DIV_DEN_W-1:0] rem_s [DIV_QUO_W];
	logic [DIV_QUO_W-1:0] nq_s  [DIV_QUO_W]; // remaining numerator bits, quotient shifted in
	logic [DIV_DEN_W-1:0] den_s [DIV_QUO_W];

	for (genvar j = 0; j < DIV_QUO_W; j++) begin : g_stage
		logic [DIV_DEN_W-1:0] rem_in;
		logic [DIV_QUO_W-1:0] nq_in;
		logic [DIV_DEN_W-1:0] den_in;
		logic [DIV_DEN_W:0]   trial;
		logic [DIV_DEN_W:0]   diff;
		logic                 ge;

		if (j == 0) begin : g_first
			// top numerator bits are below den, so they start as the remainder
			assign rem_in = num[DIV_NUM_W-1:DIV_QUO_W];
			assign nq_in  = num[DIV_QUO_W-1:0];
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_s[j-1];
			assign nq_in  = nq_s[j-1];
			assign den_in = den_s[j-1];
		end

		assign trial = {rem_in, nq_in[DIV_QUO_W-1]};
		assign ge    = trial >= {1'b0, den_in};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (stage_en[j]) begin
				rem_s[j] <= ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
				nq_s[j]  <= {nq_in[DIV_QUO_W-2:0], ge};
				den_s[j] <= den_in;
			end
		end
	end

	assign quo = nq_s[DIV_QUO_W-1];
	assign rem = rem_s[DIV_QUO_W-1];

endmodule

>>> rtl/rgb_to_hsv_converter.sv
// Each pixel passes through stage 1, stage 2, the divider stages and the output stage.
// Throughput: one pixel per clock unless the output stalls; each restoring divider has 16 stages.
// Stages advance independently, so bubbles close up under output back-pressure.
// Reset (arst_n, asynchronous, active low) clears the stage valid bits only.
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Streams 8-bit RGB pixels to hue (1/16 degree), Q0.16 saturation and value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rgb_to_hsv_converter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // hue[12:0], saturation[28:13], brightness[36:29], zero
);
	import rthc_pkg::*;

	localparam int NSTG = DIV_QUO_W + 3; // s1, s2, divider stages, output stage

	logic [NSTG-1:0] stage_vld_q;
	logic [NSTG-1:0] en;

	// a stage loads when empty or when the next one moves on
	always_comb begin
		en[NSTG-1] = !stage_vld_q[NSTG-1] || m_tready;
		for (int i = NSTG - 2; i >= 0; i--) begin
			en[i] = !stage_vld_q[i] || en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (en[0]) begin
				stage_vld_q[0] <= s_tvalid;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (en[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	assign s_tready = en[0];

	// stage 1: max, min, sector and hue operands
	logic [CHAN_W-1:0] red, green, blue;
	assign red   = s_tdata[7:0];
	assign green = s_tdata[15:8];
	assign blue  = s_tdata[23:16];

	logic [CHAN_W-1:0] mx_s1, mn_s1, opa_s1, opb_s1;
	logic [1:0]        sector_s1;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			if (red >= green && red >= blue) begin
				mx_s1     <= red;
				sector_s1 <= SEC_RED;
				opa_s1    <= green;
				opb_s1    <= blue;
			end else if (green >= blue) begin
				mx_s1     <= green;
				sector_s1 <= SEC_GREEN;
				opa_s1    <= blue;
				opb_s1    <= red;
			end else begin
				mx_s1     <= blue;
				sector_s1 <= SEC_BLUE;
				opa_s1    <= red;
				opb_s1    <= green;
			end
			if (red <= green && red <= blue) begin
				mn_s1 <= red;
			end else if (green <= blue) begin
				mn_s1 <= green;
			end else begin
				mn_s1 <= blue;
			end
		end
	end

	// stage 2: delta and signed hue difference as sign and magnitude
	logic [CHAN_W-1:0] bright_s2, delta_s2, mag_s2;
	logic [1:0]        sector_s2;
	logic              neg_s2;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			bright_s2 <= mx_s1;
			delta_s2  <= mx_s1 - mn_s1;
			sector_s2 <= sector_s1;
			neg_s2    <= opa_s1 < opb_s1;
			mag_s2    <= (opa_s1 < opb_s1) ? opb_s1 - opa_s1 : opa_s1 - opb_s1;
		end
	end

	// numerators: 960*mag and 65535*delta
	logic [17:0]          hue_num;
	logic [DIV_NUM_W-1:0] sat_num;
	assign hue_num = {mag_s2, 10'd0} - {4'd0, mag_s2, 6'd0};
	assign sat_num = {delta_s2, 16'd0} - {16'd0, delta_s2};

	logic [DIV_QUO_W-1:0] hue_quo, sat_quo;
	logic [DIV_DEN_W-1:0] hue_rem, sat_rem;

	rthc_div u_hue_div (
		.clk      (clk),
		.stage_en (en[DIV_QUO_W+1:2]),
		.num      ({6'd0, hue_num}),
		.den      (delta_s2),
		.quo      (hue_quo),
		.rem      (hue_rem)
	);

	rthc_div u_sat_div (
		.clk      (clk),
		.stage_en (en[DIV_QUO_W+1:2]),
		.num      (sat_num),
		.den      (bright_s2),
		.quo      (sat_quo),
		.rem      (sat_rem)
	);

	side_t side_s [DIV_QUO_W]; // one entry per divider stage

	for (genvar j = 0; j < DIV_QUO_W; j++) begin : g_side
		if (j == 0) begin : g_head
			always_ff @(posedge clk) begin
				if (en[j+2]) begin
					side_s[j] <= '{bright: bright_s2, sector: sector_s2,
						neg: neg_s2, grey: (delta_s2 == '0)};
				end
			end
		end else begin : g_tail
			always_ff @(posedge clk) begin
				if (en[j+2]) begin
					side_s[j] <= side_s[j-1];
				end
			end
		end
	end

	// output stage: floor for negative differences, sector offset, wrap
	side_t             side_last;
	logic [HUE_W-1:0]  hue_off, hue_base, hue_fin;
	logic [10:0]       hue_mag;

	assign side_last = side_s[DIV_QUO_W-1];
	assign hue_mag   = {1'b0, hue_quo[9:0]}
		+ {10'd0, side_last.neg && (hue_rem != '0)};

	always_comb begin
		case (side_last.sector)
			SEC_RED:   hue_off = '0;
			SEC_GREEN: hue_off = HUE_SECTOR << 1;
			SEC_BLUE:  hue_off = HUE_SECTOR << 2;
			default:   hue_off = '0;
		endcase
		hue_base = ({2'd0, hue_mag} > hue_off) ? hue_off + HUE_FULL : hue_off;
		if (side_last.neg) begin
			hue_fin = hue_base - {2'd0, hue_mag};
		end else begin
			hue_fin = hue_off + {2'd0, hue_mag};
		end
	end

	logic [HUE_W-1:0]  hue_s19;
	logic [SAT_W-1:0]  sat_s19;
	logic [CHAN_W-1:0] bright_s19;

	always_ff @(posedge clk) begin
		if (en[NSTG-1]) begin
			hue_s19    <= side_last.grey ? '0 : hue_fin;
			sat_s19    <= side_last.grey ? '0 : sat_quo;
			bright_s19 <= side_last.bright;
		end
	end

	assign m_tvalid = stage_vld_q[NSTG-1];
	assign m_tdata  = {3'd0, bright_s19, sat_s19, hue_s19};

	`ASSERT_CLK(a_hue_range, clk, arst_n, m_tvalid |-> (hue_s19 < HUE_FULL),
		"hue out of range")
	`ASSERT_CLK(a_stall_cause, clk, arst_n, !s_tready |-> (m_tvalid && !m_tready),
		"input stalled without output back-pressure")
	`ASSERT_CLK(a_black_sat, clk, arst_n,
		(m_tvalid && bright_s19 == '0) |-> (sat_s19 == '0 && hue_s19 == '0),
		"black pixel with non-zero hue or saturation")
	`ASSERT_CLK(a_div_bounds, clk, arst_n,
		(stage_vld_q[NSTG-2] && !side_last.grey) |->
		(hue_quo <= DIV_QUO_W'(HUE_SECTOR) && sat_rem < side_last.bright),
		"divider result out of bounds")

endmodule

>>> tb/rgb_to_hsv_converter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_checker
// Watches both stream channels of the converter. Each input transfer is turned
// into its expected hue, saturation and value. Each output transfer is checked
// field by field against the oldest expected pixel.
// ----------------------------------------------------------------------------

module rgb_to_hsv_converter_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [23:0] s_tdata,  // red[7:0], green[15:8], blue[23:16]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,  // hue[12:0], saturation[28:13], brightness[36:29], zero
	output int          fail_count,
	output int          pixels_in_flight
);

	import rthc_pkg::*;

	localparam int SECTOR_SPAN = 960;
	localparam int FULL_CIRCLE = 5760;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [SAT_W-1:0]  sat;
		logic [CHAN_W-1:0] bright;
	} hsv_t;

	hsv_t expected_hsv[$];

	function automatic hsv_t hsv_of(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		int   mx;
		int   mn;
		int   delta;
		int   num;
		int   base;
		int   quo;
		int   hue;
		hsv_t res;
		mx = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = mx - mn;
		hue = 0;
		if (delta != 0) begin
			// ties resolve red first, then green
			if (mx == r) begin
				num  = SECTOR_SPAN * (int'(g) - int'(b));
				base = 0;
			end else if (mx == g) begin
				num  = SECTOR_SPAN * (int'(b) - int'(r));
				base = 2 * SECTOR_SPAN;
			end else begin
				num  = SECTOR_SPAN * (int'(r) - int'(g));
				base = 4 * SECTOR_SPAN;
			end
			// division rounds towards minus infinity
			if (num >= 0)
				quo = num / delta;
			else
				quo = -((-num + delta - 1) / delta);
			hue = quo + base;
			if (hue < 0)
				hue += FULL_CIRCLE;
		end
		res.hue    = hue[HUE_W-1:0];
		res.sat    = (mx == 0) ? '0 : SAT_W'((65535 * delta) / mx);
		res.bright = mx[CHAN_W-1:0];
		return res;
	endfunction

	task automatic report(input string field, input int exp_val, input int act_val);
		fail_count++;
		$display("%0t ns: %s mismatch, expected %0d, actual %0d",
			$time, field, exp_val, act_val);
	endtask

	initial begin
		fail_count       = 0;
		pixels_in_flight = 0;
	end

	always @(posedge clk) begin
		hsv_t exp_px;
		hsv_t got_px;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_hsv.push_back(hsv_of(s_tdata[7:0], s_tdata[15:8],
					s_tdata[23:16]));
			if (m_tvalid && m_tready) begin
				got_px.hue    = m_tdata[12:0];
				got_px.sat    = m_tdata[28:13];
				got_px.bright = m_tdata[36:29];
				if (expected_hsv.size() == 0) begin
					fail_count++;
					$display("%0t ns: result with nothing expected, actual hue %0d sat %0d val %0d",
						$time, got_px.hue, got_px.sat, got_px.bright);
				end else begin
					exp_px = expected_hsv.pop_front();
					if (got_px.hue !== exp_px.hue)
						report("hue", exp_px.hue, got_px.hue);
					if (got_px.sat !== exp_px.sat)
						report("saturation", exp_px.sat, got_px.sat);
					if (got_px.bright !== exp_px.bright)
						report("brightness", exp_px.bright, got_px.bright);
				end
			end
			pixels_in_flight = expected_hsv.size();
		end
	end

endmodule

>>> tb/rgb_to_hsv_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Drives pixels into the converter: a directed set of corner pixels, then
// random pixels over three idling phases, one with a long output hold-off.
// The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------

module rgb_to_hsv_converter_tb;

	localparam int PIXELS_PER_PHASE = 283;
	localparam int HOLD_OFF_CYCLES  = 300;
	localparam int DRAIN_CYCLES     = 60;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [23:0] s_tdata;   // red[7:0], green[15:8], blue[23:16]
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // hue[12:0], saturation[28:13], brightness[36:29], zero
	int          fail_count;
	int          pixels_in_flight;

	int tx_idle_pct;
	int rx_idle_pct;
	int rx_hold_left;

	rgb_to_hsv_converter u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	rgb_to_hsv_converter_checker u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.s_tdata          (s_tdata),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.m_tdata          (m_tdata),
		.fail_count       (fail_count),
		.pixels_in_flight (pixels_in_flight)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// output side: random stalls, or a long hold-off when one is requested
	always @(negedge clk) begin
		if (rx_hold_left > 0) begin
			m_tready <= 1'b0;
			rx_hold_left--;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {b, g, r};
		do
			@(posedge clk);
		while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	task automatic send_random_pixels(input int count);
		logic [7:0] hi;
		logic [7:0] lo;
		for (int i = 0; i < count; i++) begin
			hi = 8'($urandom_range(0, 255));
			lo = 8'($urandom_range(0, hi));
			case ($urandom_range(0, 9))
				6: send_pixel(hi, hi, hi);
				7: begin
					// at least two channels share the maximum
					case ($urandom_range(0, 2))
						0: send_pixel(hi, hi, lo);
						1: send_pixel(lo, hi, hi);
						default: send_pixel(hi, lo, hi);
					endcase
				end
				8: send_pixel(8'($urandom_range(0, 3)), 8'($urandom_range(0, 3)),
					8'($urandom_range(0, 3)));
				9: send_pixel($urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(0, 2)),
					$urandom_range(0, 1) ? 8'd255 : 8'($urandom_range(0, 2)),
					8'($urandom_range(252, 255)));
				default: send_pixel(8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		m_tready     = 1'b0;
		tx_idle_pct  = 9;
		rx_idle_pct  = 48;
		rx_hold_left = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// black, white, grey
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		// primaries and their smallest non-zero forms
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		// ties on the maximum
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		send_pixel(8'd200, 8'd200, 8'd199);
		// the first two wrap the hue (red largest, blue above green); more mixed pixels follow
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd255);
		send_pixel(8'd255, 8'd1, 8'd0);
		send_pixel(8'd1, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd254, 8'd255);
		send_pixel(8'd254, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd170, 8'd85, 8'd0);
		send_pixel(8'd3, 8'd2, 8'd1);

		send_random_pixels(PIXELS_PER_PHASE);
		tx_idle_pct = 48;
		rx_idle_pct = 9;
		send_random_pixels(PIXELS_PER_PHASE);
		tx_idle_pct  = 0;
		rx_idle_pct  = 0;
		rx_hold_left = HOLD_OFF_CYCLES;
		send_random_pixels(PIXELS_PER_PHASE);
		s_tvalid <= 1'b0;

		wait (pixels_in_flight == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule
